// ===== src/bfifo_pkg.sv =====
// bfifo_pkg: command codes, field widths and shared types for the byte ring FIFO.
// No dependencies; imported by every module of the block.
package bfifo_pkg;

  localparam int unsigned CMD_W  = 3;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned AMT_W  = 11;
  localparam int unsigned OFF_W  = 10;
  localparam int unsigned CNT_W  = 11;

  localparam logic [CMD_W-1:0] CMD_PUT     = 3'd0;
  localparam logic [CMD_W-1:0] CMD_GET     = 3'd1;
  localparam logic [CMD_W-1:0] CMD_PEEK    = 3'd2;
  localparam logic [CMD_W-1:0] CMD_ERASE   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_ADV_WR  = 3'd4;
  localparam logic [CMD_W-1:0] CMD_CLEAR   = 3'd5;

  typedef logic [BYTE_W-1:0] byte_t;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_ctl_t;

endpackage

// ===== src/bfifo_mem.sv =====
// bfifo_mem: byte storage array, one write port and one registered read port.
// Depends on bfifo_pkg.
module bfifo_mem
  import bfifo_pkg::*;
#(
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  mem_ctl_t      ctl,
  input  logic [AW-1:0] wr_addr,
  input  byte_t         wr_data,
  input  logic [AW-1:0] rd_addr,
  output byte_t         rd_data
);

  byte_t mem [DEPTH];
  byte_t rd_data_r;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== src/bfifo_ctrl.sv =====
// bfifo_ctrl: read/write indices, fill level and the result registers for one command.
// Depends on bfifo_pkg; drives the storage ports of bfifo_mem.
module bfifo_ctrl
  import bfifo_pkg::*;
#(
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned CW = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             accept,
  input  logic [CMD_W-1:0] command,
  input  logic [AMT_W-1:0] amount,
  input  logic [OFF_W-1:0] offset,
  output mem_ctl_t         mem_ctl,
  output logic [AW-1:0]    wr_addr,
  output logic [AW-1:0]    rd_addr,
  output logic             data_valid,
  output logic [CNT_W-1:0] moved,
  output logic [CNT_W-1:0] data_count,
  output logic [CNT_W-1:0] free_count
);

  localparam int unsigned SW = ((CW > AMT_W) ? CW : AMT_W) + 1;

  logic [AW-1:0] ri_r, ri_nxt;
  logic [AW-1:0] wi_r, wi_nxt;
  logic [CW-1:0] fill_r, fill_nxt;
  logic          valid_r, valid_nxt;
  logic [SW-1:0] moved_r, moved_nxt;

  logic [SW-1:0] fill_ext, amt_ext, off_ext, room, depth_ext, free_ext;
  mem_ctl_t      ctl;

  function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
                                             input logic [SW-1:0] step);
    logic [SW-1:0] sum;
    sum = SW'(base) + step;
    if (sum >= SW'(DEPTH)) begin
      sum = sum - SW'(DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  assign depth_ext = SW'(DEPTH);
  assign fill_ext  = SW'(fill_r);
  assign amt_ext   = SW'(amount);
  assign off_ext   = SW'(offset);
  assign room      = depth_ext - fill_ext;

  always_comb begin
    ri_nxt    = ri_r;
    wi_nxt    = wi_r;
    fill_nxt  = fill_r;
    valid_nxt = 1'b0;
    moved_nxt = '0;
    ctl       = '0;
    rd_addr   = ri_r;
    unique case (command)
      CMD_PUT: begin
        if (fill_ext < depth_ext) begin
          ctl.wr_en = 1'b1;
          wi_nxt    = wrap_add(wi_r, SW'(1));
          fill_nxt  = fill_r + CW'(1);
          moved_nxt = SW'(1);
        end
      end
      CMD_GET: begin
        if (fill_ext != '0) begin
          ctl.rd_en = 1'b1;
          valid_nxt = 1'b1;
          ri_nxt    = wrap_add(ri_r, SW'(1));
          fill_nxt  = fill_r - CW'(1);
          moved_nxt = SW'(1);
        end
      end
      CMD_PEEK: begin
        rd_addr = wrap_add(ri_r, off_ext);
        if (off_ext < fill_ext) begin
          ctl.rd_en = 1'b1;
          valid_nxt = 1'b1;
        end
      end
      CMD_ERASE: begin
        moved_nxt = (amt_ext < fill_ext) ? amt_ext : fill_ext;
        ri_nxt    = wrap_add(ri_r, moved_nxt);
        fill_nxt  = CW'(fill_ext - moved_nxt);
      end
      CMD_ADV_WR: begin
        moved_nxt = (amt_ext < room) ? amt_ext : room;
        wi_nxt    = wrap_add(wi_r, moved_nxt);
        fill_nxt  = CW'(fill_ext + moved_nxt);
      end
      CMD_CLEAR: begin
        ri_nxt   = '0;
        wi_nxt   = '0;
        fill_nxt = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ri_r   <= '0;
      wi_r   <= '0;
      fill_r <= '0;
    end else if (accept) begin
      ri_r   <= ri_nxt;
      wi_r   <= wi_nxt;
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      valid_r <= valid_nxt;
      moved_r <= moved_nxt;
    end
  end

  assign mem_ctl.wr_en = ctl.wr_en & accept;
  assign mem_ctl.rd_en = ctl.rd_en & accept;
  assign wr_addr       = wi_r;

  assign free_ext   = depth_ext - fill_ext;
  assign data_valid = valid_r;
  assign moved      = moved_r[CNT_W-1:0];
  assign data_count = fill_ext[CNT_W-1:0];
  assign free_count = free_ext[CNT_W-1:0];

endmodule

// ===== src/byte_ring_fifo_unit.sv =====
// byte_ring_fifo_unit: byte circular FIFO, one command per transaction, one result each.
// Result: registered, valid in the cycle after the command is accepted (storage read is registered).
// Throughput: one command per cycle; in_ready drops only while a result waits on out_ready.
// Reset (rst_n, synchronous): indices and fill level go to zero, result register empties;
// storage contents are not cleared. Depends on bfifo_pkg, bfifo_ctrl, bfifo_mem.
module byte_ring_fifo_unit
  import bfifo_pkg::*;
#(
  parameter int unsigned DEPTH = 1024
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [CMD_W-1:0] in_command,
  input  logic [7:0]       in_data_in,
  input  logic [AMT_W-1:0] in_amount,
  input  logic [OFF_W-1:0] in_offset,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [7:0]       out_data_out,
  output logic             out_data_valid,
  output logic [CNT_W-1:0] out_moved,
  output logic [CNT_W-1:0] out_data_count,
  output logic [CNT_W-1:0] out_free_count
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic          accept;
  logic          out_valid_r, out_valid_nxt;
  mem_ctl_t      mem_ctl;
  logic [AW-1:0] wr_addr, rd_addr;
  byte_t         rd_data;
  logic          data_valid;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  bfifo_ctrl #(.DEPTH(DEPTH)) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .command    (in_command),
    .amount     (in_amount),
    .offset     (in_offset),
    .mem_ctl    (mem_ctl),
    .wr_addr    (wr_addr),
    .rd_addr    (rd_addr),
    .data_valid (data_valid),
    .moved      (out_moved),
    .data_count (out_data_count),
    .free_count (out_free_count)
  );

  bfifo_mem #(.DEPTH(DEPTH)) u_mem (
    .clk     (clk),
    .ctl     (mem_ctl),
    .wr_addr (wr_addr),
    .wr_data (in_data_in),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign out_valid      = out_valid_r;
  assign out_data_valid = data_valid;
  assign out_data_out   = data_valid ? rd_data : '0;

endmodule

// ===== dv/tb_top.sv =====
// tb_top: self-checking bench for byte_ring_fifo_unit. It drives command transactions,
// predicts every result with its own ring model, and compares field by field.
// Depends on bfifo_pkg and byte_ring_fifo_unit.
module tb_top;
  import bfifo_pkg::*;

  localparam int unsigned DEPTH          = 1024;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned TAIL_CYCLES    = 8;
  localparam int unsigned LONG_HOLD      = 200;

  localparam logic [CMD_W-1:0] CMD_UNDEF_6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_UNDEF_7 = 3'd7;

  typedef struct packed {
    byte_t            data;
    logic             valid;
    logic [CNT_W-1:0] moved;
    logic [CNT_W-1:0] count;
    logic [CNT_W-1:0] free;
  } fifo_result_t;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             in_valid;
  logic             in_ready;
  logic [CMD_W-1:0] in_command;
  logic [7:0]       in_data_in;
  logic [AMT_W-1:0] in_amount;
  logic [OFF_W-1:0] in_offset;
  logic             out_valid;
  logic             out_ready;
  logic [7:0]       out_data_out;
  logic             out_data_valid;
  logic [CNT_W-1:0] out_moved;
  logic [CNT_W-1:0] out_data_count;
  logic [CNT_W-1:0] out_free_count;

  byte_ring_fifo_unit #(.DEPTH(DEPTH)) DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_command     (in_command),
    .in_data_in     (in_data_in),
    .in_amount      (in_amount),
    .in_offset      (in_offset),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data_out   (out_data_out),
    .out_data_valid (out_data_valid),
    .out_moved      (out_moved),
    .out_data_count (out_data_count),
    .out_free_count (out_free_count)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ring model
  byte_t       ring_mem [DEPTH];
  bit          ring_written [DEPTH];
  int unsigned head_ptr = 0;
  int unsigned tail_ptr = 0;
  int unsigned fill     = 0;

  fifo_result_t pending_results [$];
  fifo_result_t want;
  int unsigned  mismatch_count = 0;
  int unsigned  idle_cycles    = 0;
  int           burst_left     = 0;
  bit           tx_bursty      = 1'b1;
  int           rx_hold_req    = 0;

  function automatic fifo_result_t predict_fifo_result(input logic [CMD_W-1:0] cmd,
                                                       input byte_t din,
                                                       input logic [AMT_W-1:0] amt,
                                                       input logic [OFF_W-1:0] off);
    fifo_result_t r;
    int unsigned  room;
    int unsigned  n;
    r = '0;
    room = DEPTH - fill;
    case (cmd)
      CMD_PUT: begin
        if (fill < DEPTH) begin
          ring_mem[tail_ptr]     = din;
          ring_written[tail_ptr] = 1'b1;
          tail_ptr = (tail_ptr + 1) % DEPTH;
          fill++;
          r.moved = CNT_W'(1);
        end
      end
      CMD_GET: begin
        if (fill > 0) begin
          r.data  = ring_mem[head_ptr];
          r.valid = 1'b1;
          head_ptr = (head_ptr + 1) % DEPTH;
          fill--;
          r.moved = CNT_W'(1);
        end
      end
      CMD_PEEK: begin
        if (off < fill) begin
          r.data  = ring_mem[(head_ptr + off) % DEPTH];
          r.valid = 1'b1;
        end
      end
      CMD_ERASE: begin
        n = (amt < fill) ? amt : fill;
        head_ptr = (head_ptr + n) % DEPTH;
        fill -= n;
        r.moved = CNT_W'(n);
      end
      CMD_ADV_WR: begin
        n = (amt < room) ? amt : room;
        tail_ptr = (tail_ptr + n) % DEPTH;
        fill += n;
        r.moved = CNT_W'(n);
      end
      CMD_CLEAR: begin
        head_ptr = 0;
        tail_ptr = 0;
        fill     = 0;
      end
      default: ;
    endcase
    r.count = CNT_W'(fill);
    r.free  = CNT_W'(DEPTH - fill);
    return r;
  endfunction

  // never read a slot that was only committed by advance write and never stored
  function automatic void avoid_unwritten(inout logic [CMD_W-1:0] cmd,
                                          inout logic [AMT_W-1:0] amt,
                                          inout logic [OFF_W-1:0] off);
    if (cmd == CMD_GET && fill != 0 && !ring_written[head_ptr]) begin
      cmd = CMD_ERASE;
      amt = AMT_W'(1);
    end else if (cmd == CMD_PEEK && off < fill &&
                 !ring_written[(head_ptr + off) % DEPTH]) begin
      if (fill < DEPTH && $urandom_range(1, 0) == 1) begin
        off = OFF_W'(fill);
      end else if (ring_written[head_ptr]) begin
        off = '0;
      end else begin
        cmd = CMD_ERASE;
        amt = AMT_W'(1);
      end
    end
  endfunction

  task automatic send_cmd(input logic [CMD_W-1:0] cmd, input byte_t din,
                          input logic [AMT_W-1:0] amt, input logic [OFF_W-1:0] off);
    logic [CMD_W-1:0] c;
    logic [AMT_W-1:0] a;
    logic [OFF_W-1:0] o;
    int               gap;
    c = cmd;
    a = amt;
    o = off;
    avoid_unwritten(c, a, o);
    in_valid   <= 1'b1;
    in_command <= c;
    in_data_in <= din;
    in_amount  <= a;
    in_offset  <= o;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(predict_fifo_result(c, din, a, o));
    if (tx_bursty) begin
      if (burst_left <= 0) begin
        burst_left = $urandom_range(24, 1);
        gap = ($urandom_range(9, 0) < 4) ? 0 : $urandom_range(6, 1);
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic wait_results_done();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic send_random(input logic [CMD_W-1:0] cmd);
    logic [AMT_W-1:0] amt;
    logic [OFF_W-1:0] off;
    int unsigned      sel;
    int unsigned      reach;
    sel = $urandom_range(19, 0);
    if (sel < 15) amt = AMT_W'($urandom_range(8, 0));
    else if (sel < 18) amt = AMT_W'($urandom_range(DEPTH, 0));
    else amt = AMT_W'($urandom_range(2047, 0));
    reach = (fill + 2 > DEPTH - 1) ? DEPTH - 1 : fill + 2;
    if ($urandom_range(9, 0) < 6) off = OFF_W'($urandom_range(reach, 0));
    else off = OFF_W'($urandom_range(DEPTH - 1, 0));
    send_cmd(cmd, BYTE_W'($urandom_range(255, 0)), amt, off);
  endtask

  task automatic test_empty_buffer();
    send_cmd(CMD_GET,    8'h00, '0, '0);
    send_cmd(CMD_PEEK,   8'h00, '0, '0);
    send_cmd(CMD_PEEK,   8'h00, '0, '1);
    send_cmd(CMD_ERASE,  8'h00, '0, '0);
    send_cmd(CMD_ERASE,  8'h00, '1, '0);
  endtask

  task automatic test_put_get_extremes();
    send_cmd(CMD_PUT,  8'h00, '0, '0);
    send_cmd(CMD_PUT,  8'hFF, '0, '0);
    send_cmd(CMD_PUT,  8'hA5, '0, '0);
    send_cmd(CMD_PUT,  8'h5A, '0, '0);
    send_cmd(CMD_PEEK, 8'h00, '0, 10'd0);
    send_cmd(CMD_PEEK, 8'h00, '0, 10'd3);
    send_cmd(CMD_PEEK, 8'h00, '0, 10'd4);
    send_cmd(CMD_GET,  8'h00, '0, '0);
    send_cmd(CMD_GET,  8'h00, '0, '0);
  endtask

  task automatic test_clamped_erase_and_commit();
    send_cmd(CMD_ERASE,  8'h00, 11'd1024, '0);
    send_cmd(CMD_CLEAR,  8'h00, '0, '0);
    send_cmd(CMD_ADV_WR, 8'h00, 11'd3, '0);
    send_cmd(CMD_GET,    8'h00, '0, '0);
    send_cmd(CMD_PEEK,   8'h00, '0, 10'd1);
  endtask

  task automatic test_full_buffer();
    send_cmd(CMD_ADV_WR, 8'h00, '1, '0);
    send_cmd(CMD_PUT,    8'h3C, '0, '0);
    send_cmd(CMD_ADV_WR, 8'h00, 11'd1, '0);
    send_cmd(CMD_ERASE,  8'h00, 11'd1024, '0);
  endtask

  task automatic test_undefined_commands();
    send_cmd(CMD_UNDEF_6, 8'hFF, '1, '1);
    send_cmd(CMD_UNDEF_7, 8'h00, '0, '0);
    send_cmd(CMD_CLEAR,   8'h00, '0, '0);
  endtask

  // receiver holds off long enough for the block to stall its input
  task automatic test_backpressure();
    tx_bursty   = 1'b0;
    rx_hold_req = LONG_HOLD;
    repeat (30) send_random($urandom_range(1, 0) == 1 ? CMD_PUT : CMD_PEEK);
    tx_bursty = 1'b1;
    wait_results_done();
  endtask

  // store bytes, clear, recommit them with advance write, read them back
  task automatic test_commit_sequence();
    int k;
    k = $urandom_range(12, 1);
    send_cmd(CMD_CLEAR, 8'h00, '0, '0);
    repeat (k) send_cmd(CMD_PUT, BYTE_W'($urandom_range(255, 0)), '0, '0);
    send_cmd(CMD_CLEAR, 8'h00, '0, '0);
    send_cmd(CMD_ADV_WR, 8'h00, AMT_W'(k + $urandom_range(2, 0)), '0);
    repeat (k + 2) begin
      if ($urandom_range(2, 0) == 0) begin
        send_cmd(CMD_PEEK, 8'h00, '0, OFF_W'($urandom_range(k, 0)));
      end else begin
        send_cmd(CMD_GET, 8'h00, '0, '0);
      end
    end
  endtask

  task automatic test_random_traffic(input int n, input int w_put, input int w_get,
                                     input int w_peek, input int w_erase, input int w_adv,
                                     input int w_clear, input int w_undef);
    int               r;
    int               t_get;
    int               t_peek;
    int               t_erase;
    int               t_adv;
    int               t_clear;
    logic [CMD_W-1:0] cmd;
    t_get   = w_put + w_get;
    t_peek  = t_get + w_peek;
    t_erase = t_peek + w_erase;
    t_adv   = t_erase + w_adv;
    t_clear = t_adv + w_clear;
    repeat (n) begin
      r = $urandom_range(t_clear + w_undef - 1, 0);
      if (r < w_put) cmd = CMD_PUT;
      else if (r < t_get) cmd = CMD_GET;
      else if (r < t_peek) cmd = CMD_PEEK;
      else if (r < t_erase) cmd = CMD_ERASE;
      else if (r < t_adv) cmd = CMD_ADV_WR;
      else if (r < t_clear) cmd = CMD_CLEAR;
      else cmd = ($urandom_range(1, 0) == 1) ? CMD_UNDEF_6 : CMD_UNDEF_7;
      send_random(cmd);
    end
  endtask

  // receiver: rotating ready pattern, reloaded now and then; long holds on request
  initial begin
    logic [15:0] rx_pat;
    int          pat_age;
    int          hold_len;
    rx_pat  = '1;
    pat_age = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_req != 0) begin
        hold_len    = rx_hold_req;
        rx_hold_req = 0;
        out_ready <= 1'b0;
        repeat (hold_len) @(posedge clk);
      end
      if (pat_age == 0) begin
        rx_pat  = ($urandom_range(3, 0) == 0) ? 16'hFFFF :
                  (16'($urandom_range(65535, 0)) | 16'h1);
        pat_age = $urandom_range(64, 24);
      end
      out_ready <= rx_pat[0];
      rx_pat = {rx_pat[0], rx_pat[15:1]};
      pat_age--;
    end
  end

  function automatic void check_field(input string name, input logic [31:0] exp_val,
                                      input logic [31:0] act_val);
    if (exp_val !== act_val) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_val, act_val);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result transaction with nothing expected, expected none, actual %0d",
                 $time, out_data_count);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("data_out",   32'(want.data),  32'(out_data_out));
        check_field("data_valid", 32'(want.valid), 32'(out_data_valid));
        check_field("moved",      32'(want.moved), 32'(out_moved));
        check_field("data_count", 32'(want.count), 32'(out_data_count));
        check_field("free_count", 32'(want.free),  32'(out_free_count));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog, no transaction for %0d cycles", $time, idle_cycles);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    rst_n      <= 1'b0;
    in_valid   <= 1'b0;
    in_command <= CMD_PUT;
    in_data_in <= '0;
    in_amount  <= '0;
    in_offset  <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    test_empty_buffer();
    test_put_get_extremes();
    test_clamped_erase_and_commit();
    test_full_buffer();
    test_undefined_commands();
    test_backpressure();
    for (int p = 0; p < 6; p++) begin
      if (p % 2 == 0) test_random_traffic(190, 40, 10, 20, 5, 10, 1, 2);
      else test_random_traffic(190, 10, 40, 20, 15, 3, 2, 2);
      repeat (2) test_commit_sequence();
    end

    wait_results_done();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
